// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_IMPLY(label, ante, cons, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/sdds_pkg.sv =====
// ----------------------------------------------------------------------------
// sdds_pkg
// Widths, constants, register indexes and sine table builder for the DDS core.
// ----------------------------------------------------------------------------
package sdds_pkg;

    localparam int PHASE_W  = 32;
    localparam int ADDR_W   = 10;
    localparam int SINE_W   = 16;
    localparam int INDEX_W  = 31;
    localparam int FREQ_W   = 23;
    localparam int AMP_W    = 16;
    localparam int LIMIT_W  = SINE_W - 1;
    localparam int LAST_W   = INDEX_W + 1;

    localparam int QUARTER_N = 1 << ADDR_W;
    localparam int ROM_AW    = ADDR_W + 1;
    localparam int K_LSB     = PHASE_W - 2 - ADDR_W;
    localparam int MAG_W     = SINE_W - 1;

    // phase increment = floor(freq * 2^INC_SHIFT / rate)
    localparam int INC_SHIFT = PHASE_W - 8;
    localparam int RECIP_EXP = INC_SHIFT + FREQ_W;
    localparam int RECIP_W   = PHASE_W;
    localparam int PROD_W    = FREQ_W + RECIP_W;
    localparam int RATE_W    = 16;
    localparam int REM_W     = RATE_W + 1;

    localparam logic [RATE_W-1:0]  RATE_48K  = RATE_W'(48000);
    localparam logic [RATE_W-1:0]  RATE_44K  = RATE_W'(44100);
    localparam logic [RECIP_W-1:0] RECIP_48K = RECIP_W'((64'd1 << RECIP_EXP) / 64'd48000);
    localparam logic [RECIP_W-1:0] RECIP_44K = RECIP_W'((64'd1 << RECIP_EXP) / 64'd44100);

    localparam logic [LIMIT_W-1:0] CLAMP_RESET = LIMIT_W'(30000);

    localparam logic REG_RATE_SELECT = 1'b0;
    localparam logic REG_CLAMP_LIMIT = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_MAX     = (64'd1 << (SINE_W - 1)) - 64'd1;

    typedef struct packed {
        logic mul_en;
        logic corr_en;
    } inc_ctl_t;

    typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER_N];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] scaled;
        longint      sum;
        for (int k = 0; k <= QUARTER_N; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> ADDR_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            scaled = (64'(sum) * AMP_MAX + (64'd1 << 29)) >> 30;
            rom[k] = scaled[MAG_W-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/sdds_inc.sv =====
// ----------------------------------------------------------------------------
// sdds_inc
// Phase increment: reciprocal multiply, then one-step remainder correction.
// ----------------------------------------------------------------------------
module sdds_inc (
    input  logic                          clk,
    input  sdds_pkg::inc_ctl_t            ctl,
    input  logic                          rate_select,
    input  logic [sdds_pkg::FREQ_W-1:0]   freq_hz,
    output logic [sdds_pkg::PHASE_W-1:0]  inc
);
    import sdds_pkg::*;

    logic [PROD_W-1:0]  prod_reg;
    logic [RECIP_W-1:0] quot_reg;
    logic [REM_W-1:0]   low_reg;
    logic [RECIP_W-1:0] recip;
    logic [RATE_W-1:0]  rate;
    logic [RECIP_W-1:0] quot;
    logic [REM_W-1:0]   rem;
    logic               corr;

    assign recip = rate_select ? RECIP_44K : RECIP_48K;
    assign rate  = rate_select ? RATE_44K : RATE_48K;
    assign quot  = prod_reg[PROD_W-1:FREQ_W];

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(freq_hz) * PROD_W'(recip);
        end
        if (ctl.corr_en)
        begin
            quot_reg <= quot;
            low_reg  <= REM_W'(quot[REM_W-1:0] * REM_W'(rate));
        end
    end

    // numerator has zero low bits, so the remainder is the negated low product
    assign rem  = REM_W'(0) - low_reg;
    assign corr = (rem >= REM_W'(rate));
    assign inc  = quot_reg + PHASE_W'(corr);

endmodule

// ===== rtl/sdds_rom.sv =====
// ----------------------------------------------------------------------------
// sdds_rom
// Quarter-wave sine table with quadrant folding and registered read.
// ----------------------------------------------------------------------------
module sdds_rom (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [sdds_pkg::PHASE_W-1:0]  phase,
    output logic [sdds_pkg::MAG_W-1:0]    mag,
    output logic                          neg
);
    import sdds_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [ROM_AW-1:0] k;
    logic [ROM_AW-1:0] addr;

    assign k    = {1'b0, phase[K_LSB +: ADDR_W]};
    assign addr = phase[PHASE_W-2] ? ROM_AW'(QUARTER_N) - k : k;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag_reg <= SINE_ROM[addr];
            neg_reg <= phase[PHASE_W-1];
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

// ===== rtl/sdds_scale.sv =====
// ----------------------------------------------------------------------------
// sdds_scale
// Amplitude multiply, floor toward minus infinity and symmetric clamp.
// ----------------------------------------------------------------------------
module sdds_scale (
    input  logic                          clk,
    input  logic                          mul_en,
    input  logic [sdds_pkg::MAG_W-1:0]    mag,
    input  logic                          neg,
    input  logic [sdds_pkg::AMP_W-1:0]    amplitude,
    input  logic [sdds_pkg::LIMIT_W-1:0]  clamp_limit,
    output logic [sdds_pkg::SINE_W-1:0]   sample,
    output logic                          clipped
);
    import sdds_pkg::*;

    localparam int P_W = MAG_W + AMP_W;

    logic [P_W-1:0]     prod_reg;
    logic               neg_reg;
    logic [P_W-1:0]     biased;
    logic [AMP_W-1:0]   mag_out;
    logic [LIMIT_W-1:0] mag_lim;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= P_W'(mag) * P_W'(amplitude);
            neg_reg  <= neg;
        end
    end

    // round magnitude up for negative values: floor of the signed product
    assign biased  = prod_reg + (neg_reg ? P_W'((1 << (SINE_W - 1)) - 1) : P_W'(0));
    assign mag_out = biased[SINE_W-1 +: AMP_W];
    assign clipped = (mag_out > AMP_W'(clamp_limit));
    assign mag_lim = clipped ? clamp_limit : mag_out[LIMIT_W-1:0];
    assign sample  = neg_reg ? SINE_W'(0) - {1'b0, mag_lim} : {1'b0, mag_lim};

endmodule

// ===== rtl/sine_oscillator_dds_core.sv =====
// ----------------------------------------------------------------------------
// sine_oscillator_dds_core
// A request passes through the multiply, correction, phase, scale and done states
// in order; a new request is taken only in idle, once the last result is loaded.
// A result waiting at the output does not block the next request.
// Reset: rate 48 kHz, clamp 30000, phase zero, no stored sample index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_oscillator_dds_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [sdds_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sdds_pkg::INDEX_W-1:0]  sample_index,
    input  logic [sdds_pkg::FREQ_W-1:0]   freq_hz,
    input  logic [sdds_pkg::AMP_W-1:0]    amplitude,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sdds_pkg::SINE_W-1:0]   sample,
    output logic                          clipped
);
    import sdds_pkg::*;

    typedef struct packed {
        logic [LAST_W-1:0]  last_index;
        logic [PHASE_W-1:0] phase;
    } osc_state_t;

    localparam osc_state_t STATE_RESET = '{last_index: '1, phase: '0};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CORR  = 3'd2;
    localparam logic [2:0] S_PHASE = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic               rate_select_reg;
    logic [LIMIT_W-1:0] clamp_limit_reg;
    logic               st_valid_reg;
    logic               out_valid_reg;

    osc_state_t         state_mem [0:0];
    osc_state_t         st_rd_reg;
    osc_state_t         st_wr;

    logic [INDEX_W-1:0] index_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [SINE_W-1:0]  sample_reg;
    logic               clipped_reg;

    inc_ctl_t           inc_ctl;
    logic [PHASE_W-1:0] inc;
    logic               advance;
    logic [PHASE_W-1:0] phase_new;
    logic [MAG_W-1:0]   rom_mag;
    logic               rom_neg;
    logic [SINE_W-1:0]  scale_sample;
    logic               scale_clipped;
    logic               in_accept;
    logic               out_load;
    logic [SINE_W-1:0]  lim_pos;
    logic [SINE_W-1:0]  lim_neg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign inc_ctl.mul_en  = (state_reg == S_MUL);
    assign inc_ctl.corr_en = (state_reg == S_CORR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_MUL;
            S_MUL:   state_next = S_CORR;
            S_CORR:  state_next = S_PHASE;
            S_PHASE: state_next = S_SCALE;
            S_SCALE: state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rate_select_reg <= 1'b0;
            clamp_limit_reg <= CLAMP_RESET;
            st_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_RATE_SELECT: rate_select_reg <= cfg_wdata[0];
                    REG_CLAMP_LIMIT: clamp_limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == S_PHASE)
            begin
                st_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // capture request, read oscillator state
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            index_reg <= sample_index;
            freq_reg  <= freq_hz;
            amp_reg   <= amplitude;
            st_rd_reg <= st_valid_reg ? state_mem[0] : STATE_RESET;
        end
        if (state_reg == S_PHASE)
        begin
            state_mem[0] <= st_wr;
        end
        if (out_load)
        begin
            sample_reg  <= scale_sample;
            clipped_reg <= scale_clipped;
        end
    end

    // advance phase only on a new sample index
    assign advance   = ({1'b0, index_reg} != st_rd_reg.last_index);
    assign phase_new = advance ? st_rd_reg.phase + inc : st_rd_reg.phase;

    assign st_wr.last_index = advance ? {1'b0, index_reg} : st_rd_reg.last_index;
    assign st_wr.phase      = phase_new;

    sdds_inc u_inc (
        .clk         (clk),
        .ctl         (inc_ctl),
        .rate_select (rate_select_reg),
        .freq_hz     (freq_reg),
        .inc         (inc)
    );

    sdds_rom u_rom (
        .clk   (clk),
        .rd_en (state_reg == S_PHASE),
        .phase (phase_new),
        .mag   (rom_mag),
        .neg   (rom_neg)
    );

    sdds_scale u_scale (
        .clk         (clk),
        .mul_en      (state_reg == S_SCALE),
        .mag         (rom_mag),
        .neg         (rom_neg),
        .amplitude   (amp_reg),
        .clamp_limit (clamp_limit_reg),
        .sample      (scale_sample),
        .clipped     (scale_clipped)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign clipped   = clipped_reg;

    assign lim_pos = {1'b0, clamp_limit_reg};
    assign lim_neg = SINE_W'(0) - lim_pos;

    `ASSERT_NEXT(a_accept_starts, in_accept, state_reg == S_MUL, "request did not start work")
    `ASSERT_NEXT(a_state_written, state_reg == S_PHASE, st_valid_reg, "state memory not written")
    `ASSERT_IMPLY(a_clip_value, out_valid && clipped, (sample == lim_pos) || (sample == lim_neg), "clipped sample off limit")
    `ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && out_valid && !out_ready, state_reg == S_DONE, "result dropped")

endmodule

// ===== bench/sdds_tone_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdds_tone_checker
// Watches the register port and the request and result channels of the DDS core.
// Tracks its own phase accumulator and last sample index, rebuilds the
// quarter-wave table, predicts each sample and clip flag, and compares every
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module sdds_tone_checker
    import sdds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [INDEX_W-1:0] sample_index,
    input  logic [FREQ_W-1:0]  freq_hz,
    input  logic [AMP_W-1:0]   amplitude,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [SINE_W-1:0]  sample,
    input  logic               clipped,
    output int                 fail_count,
    output int                 pending,
    output int                 request_count,
    output int                 repeat_count,
    output int                 clip_count
);

    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [63:0] PEAK_CODE        = (64'd1 << (SINE_W - 1)) - 64'd1;

    typedef struct packed {
        logic [SINE_W-1:0] sample;
        logic              clipped;
    } tone_t;

    logic [MAG_W-1:0]   tone_rom [0:QUARTER_N];
    tone_t              pending_tones [$];
    logic               rate_44k   = 1'b0;
    logic [LIMIT_W-1:0] clamp_lim  = LIMIT_W'(30000);
    logic [PHASE_W-1:0] phase      = '0;
    logic [LAST_W-1:0]  last_index = '1;

    function automatic logic [MAG_W-1:0] quarter_wave_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      acc;
        x    = (64'(k) * QUARTER_TURN_Q30) >> ADDR_W;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(1) << 30))
            acc = longint'(1) << 30;
        mag = (64'(acc) * PEAK_CODE + (64'd1 << 29)) >> 30;
        return mag[MAG_W-1:0];
    endfunction

    function automatic tone_t tone_for_phase(input logic [PHASE_W-1:0] ph,
                                             input logic [AMP_W-1:0]   amp,
                                             input logic [LIMIT_W-1:0] limit);
        tone_t       t;
        logic [1:0]  quad;
        int unsigned k;
        longint      s;
        longint      prod;
        longint      v;
        longint      lim;
        quad = ph[PHASE_W-1 -: 2];
        k    = ph[PHASE_W-3 -: ADDR_W];
        if (quad[0])
            k = QUARTER_N - k;
        s = longint'(tone_rom[k]);
        if (quad[1])
            s = -s;
        prod      = s * longint'(amp);
        v         = prod >>> (SINE_W - 1);
        lim       = longint'(limit);
        t.clipped = 1'b0;
        if (v > lim)
        begin
            v         = lim;
            t.clipped = 1'b1;
        end
        else if (v < -lim)
        begin
            v         = -lim;
            t.clipped = 1'b1;
        end
        t.sample = v[SINE_W-1:0];
        return t;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        request_count = 0;
        repeat_count  = 0;
        clip_count    = 0;
        for (int unsigned k = 0; k <= QUARTER_N; k++)
            tone_rom[k] = quarter_wave_entry(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        tone_t         want;
        logic [63:0]   step;
        longint unsigned rate;
        if (!rst_n)
        begin
            rate_44k   = 1'b0;
            clamp_lim  = LIMIT_W'(30000);
            phase      = '0;
            last_index = '1;
            pending_tones.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_RATE_SELECT)
                    rate_44k = cfg_wdata[0];
                else if (cfg_index == REG_CLAMP_LIMIT)
                    clamp_lim = cfg_wdata;
            end

            if (out_valid && out_ready)
            begin
                if (pending_tones.size() == 0)
                begin
                    $error("sample: expected none, actual %0d", $signed(sample));
                    fail_count++;
                end
                else
                begin
                    want = pending_tones.pop_front();
                    if (sample !== want.sample)
                    begin
                        $error("sample: expected %0d, actual %0d",
                               $signed(want.sample), $signed(sample));
                        fail_count++;
                    end
                    if (clipped !== want.clipped)
                    begin
                        $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                request_count++;
                // advance only on a new sample index
                if ({1'b0, sample_index} != last_index)
                begin
                    rate       = rate_44k ? 44100 : 48000;
                    step       = (64'(freq_hz) << INC_SHIFT) / rate;
                    last_index = {1'b0, sample_index};
                    phase      = phase + step[PHASE_W-1:0];
                end
                else
                    repeat_count++;
                want = tone_for_phase(phase, amplitude, clamp_lim);
                if (want.clipped)
                    clip_count++;
                pending_tones.push_back(want);
            end
        end
        pending = pending_tones.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the DDS sine oscillator core. Directed requests
// cover first sample, repeated indexes, frequency and amplitude extremes and
// saturation; random streams run under several rate and clamp settings with
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import sdds_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int STREAM_LEN    = 235;
    localparam int QUARTER_48K   = 3072000;
    localparam int QUARTER_44K   = 2822400;
    localparam int FREQ_TOP      = 6144000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [INDEX_W-1:0] sample_index;
    logic [FREQ_W-1:0]  freq_hz;
    logic [AMP_W-1:0]   amplitude;
    logic               out_valid;
    logic               out_ready;
    logic [SINE_W-1:0]  sample;
    logic               clipped;

    int fail_count;
    int pending;
    int request_count;
    int repeat_count;
    int clip_count;
    int idle_cycles;
    bit hold_req;
    bit quiet;

    sine_oscillator_dds_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_index (sample_index),
        .freq_hz      (freq_hz),
        .amplitude    (amplitude),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .clipped      (clipped)
    );

    sdds_tone_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_index  (sample_index),
        .freq_hz       (freq_hz),
        .amplitude     (amplitude),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample        (sample),
        .clipped       (clipped),
        .fail_count    (fail_count),
        .pending       (pending),
        .request_count (request_count),
        .repeat_count  (repeat_count),
        .clip_count    (clip_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random short stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(input logic [INDEX_W-1:0] idx,
                                input logic [FREQ_W-1:0]  freq,
                                input logic [AMP_W-1:0]   amp);
        in_valid     <= 1'b1;
        sample_index <= idx;
        freq_hz      <= freq;
        amplitude    <= amp;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic rate_sel, input logic [LIMIT_W-1:0] limit);
        drain();
        write_reg(REG_RATE_SELECT, LIMIT_W'(rate_sel));
        write_reg(REG_CLAMP_LIMIT, limit);
    endtask

    task automatic run_stream(input int count, input int hold_at, input int quiet_from);
        logic [INDEX_W-1:0] idx;
        logic [FREQ_W-1:0]  freq;
        logic [AMP_W-1:0]   amp;
        int                 pick;
        idx = INDEX_W'($urandom);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == quiet_from)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                idx = INDEX_W'($urandom);
            else if (pick >= 25)
                idx = idx + 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                freq = FREQ_W'($urandom_range(0, FREQ_TOP));
            else if (pick < 85)
                freq = FREQ_W'($urandom);
            else
            begin
                case ($urandom_range(0, 2))
                    0:       freq = '0;
                    1:       freq = FREQ_W'(FREQ_TOP);
                    default: freq = '1;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                amp = AMP_W'($urandom);
            else if (pick < 80)
                amp = '1;
            else if (pick < 90)
                amp = '0;
            else
                amp = AMP_W'($urandom_range(1, 64));
            send_request(idx, freq, amp);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_RATE_SELECT;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        sample_index = '0;
        freq_hz      = '0;
        amplitude    = '0;
        hold_req     = 1'b0;
        quiet        = 1'b0;
        idle_cycles  = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 48 kHz, clamp 30000
        send_request('0, '1, '1);
        send_request('0, '0, '0);
        send_request('0, FREQ_W'(FREQ_TOP), '1);
        send_request('1, FREQ_W'(FREQ_TOP), '1);
        send_request(INDEX_W'(1), '0, AMP_W'(16'h8000));
        for (int i = 2; i < 10; i++)
            send_request(INDEX_W'(i), FREQ_W'(QUARTER_48K), '1);
        send_request(INDEX_W'(10), FREQ_W'(1), AMP_W'(1));

        set_mode(1'b1, '0);
        send_request(INDEX_W'(100), FREQ_W'(QUARTER_44K), '1);
        send_request(INDEX_W'(101), FREQ_W'(QUARTER_44K), '1);
        send_request(INDEX_W'(102), '0, AMP_W'(1));
        send_request(INDEX_W'(103), FREQ_W'(QUARTER_44K), '0);

        set_mode(1'b1, '1);
        for (int i = 200; i < 204; i++)
            send_request(INDEX_W'(i), FREQ_W'(QUARTER_44K), '1);
        send_request(INDEX_W'(204), '1, AMP_W'(16'h8000));

        set_mode(1'b0, LIMIT_W'(30000));
        run_stream(STREAM_LEN, -1, -1);
        set_mode(1'b1, '1);
        run_stream(STREAM_LEN, 60, -1);
        set_mode(1'b0, LIMIT_W'($urandom_range(0, 32767)));
        run_stream(STREAM_LEN, -1, -1);
        set_mode(1'b1, LIMIT_W'($urandom_range(0, 32767)));
        run_stream(STREAM_LEN, -1, 120);

        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d requests: %0d on a repeated index, %0d clipped samples,",
                 request_count, repeat_count, clip_count);
        $display("both sample rates, clamp limits 0 to 32767, stalls on both channels");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdds_pkg.sv
rtl/sdds_inc.sv
rtl/sdds_rom.sv
rtl/sdds_scale.sv
rtl/sine_oscillator_dds_core.sv
bench/sdds_tone_checker.sv
bench/tb.sv
